// File: rtl/bilinear_sample_with_gradient_assert.svh
// Assertion macros for the bilinear sampler
`ifndef BILINEAR_SAMPLE_WITH_GRADIENT_ASSERT_SVH
`define BILINEAR_SAMPLE_WITH_GRADIENT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, clocked on the rising edge, off while reset is asserted
`define BSG_ASSERT_IMP(lbl, clk_s, rstn_s, pre, post) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (pre) |-> post) \
		else $error("bilinear sampler: implication failed");
// Next-cycle implication
`define BSG_ASSERT_NXT(lbl, clk_s, rstn_s, pre, post) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (pre) |=> post) \
		else $error("bilinear sampler: next-cycle implication failed");
`else
`define BSG_ASSERT_IMP(lbl, clk_s, rstn_s, pre, post)
`define BSG_ASSERT_NXT(lbl, clk_s, rstn_s, pre, post)
`endif

`endif

// File: rtl/bsg_pkg.sv
// Shared constants and codes for the bilinear sampler with gradients
package bsg_pkg;

	localparam int FRAC_BITS   = 8;
	localparam int COORD_W     = 19;
	localparam int ADDR_IN_W   = 19;
	localparam int PIX_W       = 8;
	localparam int INTEN_W     = 16;
	localparam int GRAD_OUT_W  = 17;
	localparam int WIDTH_REG_W = 11;
	localparam int HEIGHT_REG_W = 10;
	localparam int CFG_DATA_W  = 11;
	localparam int CFG_IDX_W   = 1;
	localparam int CMP_W       = 20;

	localparam int IMG_W_DEF = 1024;
	localparam int IMG_H_DEF = 512;

	// neighborhood margin: integer point must sit this far inside the limit
	localparam int NBR_MARGIN = 3;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST  = 11'd1024;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = 10'd512;

	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

endpackage

// File: rtl/bilinear_sample_with_gradient.sv
// Bilinear sampler with gradients over a banked grayscale image store
//
// Usage: one command channel carries both kinds of beat. A beat is taken at a
// rising edge with start high and busy low. kind = write stores pixel_value at
// pixel_address (row * IMG_W + column); it yields no result. kind = sample
// interpolates at (coord_u, coord_v), signed with FRAC_BITS fraction bits, and
// yields one result beat: intensity, grad_u, grad_v and in_range, shown for one
// cycle with done high. Out-of-bounds samples return zeros with in_range low.
// Throughput: one beat per cycle when busy is low, sustained, any mix of
// writes and samples. Stages: memory read, vertical blend and gradient stage,
// horizontal blend and rounding stage. The store is kept as two identical
// copies, each read at two addresses, so the four neighbors come out in the
// same cycle; a write commits at its own accept edge, so any later sample
// reads it without forwarding. The user must write configuration (cfg_we,
// cfg_addr, cfg_wdata) only while idle; the block does not check it. Reset:
// registers return to 1024 x 512, the pipeline empties, busy is high for the
// first cycle after release. Image contents are undefined until written and
// get no clearing pass. The receiver cannot stall: results are not held.
`include "bilinear_sample_with_gradient_assert.svh"

module bilinear_sample_with_gradient #(
	parameter int IMG_W = bsg_pkg::IMG_W_DEF,
	parameter int IMG_H = bsg_pkg::IMG_H_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  kind,
	input  logic [bsg_pkg::ADDR_IN_W-1:0]         pixel_address,
	input  logic [bsg_pkg::PIX_W-1:0]             pixel_value,
	input  logic signed [bsg_pkg::COORD_W-1:0]    coord_u,
	input  logic signed [bsg_pkg::COORD_W-1:0]    coord_v,
	output logic                                  done,
	output logic [bsg_pkg::INTEN_W-1:0]           intensity,
	output logic signed [bsg_pkg::GRAD_OUT_W-1:0] grad_u,
	output logic signed [bsg_pkg::GRAD_OUT_W-1:0] grad_v,
	output logic                                  in_range,
	input  logic                                  cfg_we,
	input  logic [bsg_pkg::CFG_IDX_W-1:0]         cfg_addr,
	input  logic [bsg_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
	import bsg_pkg::*;

	localparam int DEPTH  = IMG_W * IMG_H;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int UP_W   = COORD_W - 1 - FRAC_BITS;
	localparam int WT_W   = FRAC_BITS + 1;
	localparam int COL_W  = PIX_W + FRAC_BITS;
	localparam int PROD_W = PIX_W + WT_W;
	localparam int GRAD_W = COL_W + 1;
	localparam int GP_W   = PIX_W + WT_W + 2;
	localparam int TOT_W  = PIX_W + 2 * FRAC_BITS;
	localparam int TP_W   = TOT_W + 1;
	localparam logic [WT_W-1:0] ONE_W = WT_W'(1) << FRAC_BITS;

	// configuration
	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic                    run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			run_q    <= 1'b0;
		end else begin
			run_q <= 1'b1;
			if (cfg_we) begin
				case (cfg_addr)
					REG_WIDTH:  width_q  <= cfg_wdata;
					REG_HEIGHT: height_q <= cfg_wdata[HEIGHT_REG_W-1:0];
					default:    ;
				endcase
			end
		end
	end

	assign busy = !run_q;

	// accept and address decode
	logic              acc, smp, wr_ok, neg, in_rng, rd_en;
	logic [UP_W-1:0]   up, vp;
	logic [CMP_W-1:0]  col_lim, row_lim;
	logic [ADDR_W-1:0] wr_addr, rd_addr, addr_12, addr_21, addr_22;

	always_comb begin
		acc     = start && !busy;
		smp     = acc && (kind == KIND_SAMPLE);
		wr_ok   = acc && (kind == KIND_WRITE) && (32'(pixel_address) < 32'(DEPTH));
		wr_addr = ADDR_W'(pixel_address);
		neg     = coord_u[COORD_W-1] | coord_v[COORD_W-1];
		up      = coord_u[COORD_W-2:FRAC_BITS];
		vp      = coord_v[COORD_W-2:FRAC_BITS];
		col_lim = (CMP_W'(width_q) < CMP_W'(IMG_W)) ? CMP_W'(width_q) : CMP_W'(IMG_W);
		row_lim = (CMP_W'(height_q) < CMP_W'(IMG_H)) ? CMP_W'(height_q) : CMP_W'(IMG_H);
		in_rng  = !neg
			&& (CMP_W'(up) + CMP_W'(NBR_MARGIN) <= col_lim)
			&& (CMP_W'(vp) + CMP_W'(NBR_MARGIN) <= row_lim);
		rd_en   = smp && in_rng;
		rd_addr = ADDR_W'(ADDR_W'(vp) * ADDR_W'(IMG_W) + ADDR_W'(up));
		addr_12 = ADDR_W'(rd_addr + ADDR_W'(1));
		addr_21 = ADDR_W'(rd_addr + ADDR_W'(IMG_W));
		addr_22 = ADDR_W'(addr_21 + ADDR_W'(1));
	end

	// two copies of the store: copy 0 feeds the upper row, copy 1 the lower row
	logic [PIX_W-1:0] mem0 [DEPTH];
	logic [PIX_W-1:0] mem1 [DEPTH];
	logic [PIX_W-1:0] i11_s1, i12_s1, i21_s1, i22_s1;

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem0[wr_addr] <= pixel_value;
			mem1[wr_addr] <= pixel_value;
		end
		if (rd_en) begin
			i11_s1 <= mem0[rd_addr];
			i12_s1 <= mem0[addr_12];
			i21_s1 <= mem1[addr_21];
			i22_s1 <= mem1[addr_22];
		end
	end

	// stage 1 control and fractions
	logic                 smp_s1, inr_s1;
	logic [FRAC_BITS-1:0] fu_s1, fv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_s1 <= 1'b0;
			inr_s1 <= 1'b0;
		end else begin
			smp_s1 <= smp;
			inr_s1 <= in_rng;
		end
	end

	always_ff @(posedge clk) begin
		fu_s1 <= coord_u[FRAC_BITS-1:0];
		fv_s1 <= coord_v[FRAC_BITS-1:0];
	end

	// stage 2: blend along v, vertical gradient
	logic [WT_W-1:0]          wv1, wv0, wu1, wu0;
	logic [COL_W-1:0]         col0_c, col1_c;
	logic signed [PIX_W:0]    dv0, dv1;
	logic signed [GP_W-1:0]   gv_full;

	always_comb begin
		wv1     = WT_W'(fv_s1);
		wv0     = ONE_W - wv1;
		wu1     = WT_W'(fu_s1);
		wu0     = ONE_W - wu1;
		col0_c  = COL_W'(PROD_W'(i11_s1) * PROD_W'(wv0) + PROD_W'(i21_s1) * PROD_W'(wv1));
		col1_c  = COL_W'(PROD_W'(i12_s1) * PROD_W'(wv0) + PROD_W'(i22_s1) * PROD_W'(wv1));
		dv0     = $signed({1'b0, i21_s1}) - $signed({1'b0, i11_s1});
		dv1     = $signed({1'b0, i22_s1}) - $signed({1'b0, i12_s1});
		gv_full = GP_W'(dv0) * GP_W'($signed({1'b0, wu0}))
			+ GP_W'(dv1) * GP_W'($signed({1'b0, wu1}));
	end

	logic                     smp_s2, inr_s2;
	logic [FRAC_BITS-1:0]     fu_s2;
	logic [COL_W-1:0]         col0_s2, col1_s2;
	logic signed [GRAD_W-1:0] gv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_s2 <= 1'b0;
			inr_s2 <= 1'b0;
		end else begin
			smp_s2 <= smp_s1;
			inr_s2 <= inr_s1;
		end
	end

	always_ff @(posedge clk) begin
		fu_s2   <= fu_s1;
		col0_s2 <= col0_c;
		col1_s2 <= col1_c;
		gv_s2   <= GRAD_W'(gv_full);
	end

	// stage 3: blend along u, round half up, horizontal gradient
	logic [WT_W-1:0]          hu1, hu0;
	logic [TP_W-1:0]          tot, rnd;
	logic signed [GRAD_W-1:0] gu_c;

	always_comb begin
		hu1  = WT_W'(fu_s2);
		hu0  = ONE_W - hu1;
		tot  = TP_W'(col0_s2) * TP_W'(hu0) + TP_W'(col1_s2) * TP_W'(hu1);
		rnd  = tot + (TP_W'(1) << (FRAC_BITS - 1));
		gu_c = $signed({1'b0, col1_s2}) - $signed({1'b0, col0_s2});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= smp_s2;
		end
	end

	// drop the arithmetic when the neighborhood fell outside the bounds
	always_ff @(posedge clk) begin
		in_range  <= inr_s2;
		intensity <= inr_s2 ? INTEN_W'(rnd >> FRAC_BITS) : '0;
		grad_u    <= inr_s2 ? GRAD_OUT_W'(gu_c) : '0;
		grad_v    <= inr_s2 ? GRAD_OUT_W'(gv_s2) : '0;
	end

	`BSG_ASSERT_NXT(a_sample_gives_result, clk, arst_n, acc && kind == KIND_SAMPLE, ##2 done)
	`BSG_ASSERT_IMP(a_result_has_sample, clk, arst_n, done, $past(smp, 3))
	`BSG_ASSERT_IMP(a_out_of_range_zero, clk, arst_n, done && !in_range, intensity == '0 && grad_u == '0 && grad_v == '0)

endmodule

// File: verif/tb_bilinear_sample_with_gradient.sv
// Testbench for the bilinear sampler: directed and random beats checked against a fixed-point predictor
`timescale 1ns / 1ps

module tb_bilinear_sample_with_gradient;
	import bsg_pkg::*;

	localparam int STORE_DEPTH = IMG_W_DEF * IMG_H_DEF;
	localparam int ONE         = 1 << FRAC_BITS;
	localparam int IDLE_LIMIT  = 500;

	typedef struct packed {
		logic [INTEN_W-1:0]           intensity;
		logic signed [GRAD_OUT_W-1:0] grad_u;
		logic signed [GRAD_OUT_W-1:0] grad_v;
		logic                         in_range;
	} sample_res_t;

	class sampler_scoreboard;
		byte unsigned pix [STORE_DEPTH];
		bit           seen [STORE_DEPTH];
		int           width_reg;
		int           height_reg;
		sample_res_t  pending_samples [$];
		int           errors;
		int           n_writes;
		int           n_samples;
		int           n_inside;

		function new();
			width_reg  = int'(WIDTH_RST);
			height_reg = int'(HEIGHT_RST);
		endfunction

		function void set_reg(reg_idx_t idx, int value);
			if (idx == REG_WIDTH)
				width_reg = value & ((1 << WIDTH_REG_W) - 1);
			else if (idx == REG_HEIGHT)
				height_reg = value & ((1 << HEIGHT_REG_W) - 1);
		endfunction

		function int col_limit();
			return ((width_reg < IMG_W_DEF) ? width_reg : IMG_W_DEF) - NBR_MARGIN;
		endfunction

		function int row_limit();
			return ((height_reg < IMG_H_DEF) ? height_reg : IMG_H_DEF) - NBR_MARGIN;
		endfunction

		function int pending();
			return pending_samples.size();
		endfunction

		// append at the tail of the outstanding queue
		function void queue_sample(sample_res_t r);
			pending_samples.insert(pending_samples.size(), r);
		endfunction

		function sample_res_t interpolate(logic signed [COORD_W-1:0] cu,
				logic signed [COORD_W-1:0] cv);
			sample_res_t r;
			int up, vp, fu, fv, a;
			int p11, p12, p21, p22, acc, gu, gv;
			r = '0;
			// negative coordinate means negative floor
			if (cu < 0 || cv < 0)
				return r;
			up = int'(cu[COORD_W-1:FRAC_BITS]);
			vp = int'(cv[COORD_W-1:FRAC_BITS]);
			if (up > col_limit() || vp > row_limit())
				return r;
			fu = int'(cu[FRAC_BITS-1:0]);
			fv = int'(cv[FRAC_BITS-1:0]);
			a = vp * IMG_W_DEF + up;
			p11 = pix[a];
			p12 = pix[a + 1];
			p21 = pix[a + IMG_W_DEF];
			p22 = pix[a + IMG_W_DEF + 1];
			acc = (p11 * (ONE - fv) + p21 * fv) * (ONE - fu) + (p12 * (ONE - fv) + p22 * fv) * fu;
			gu = (p22 - p21) * fv + (p12 - p11) * (ONE - fv);
			gv = (p22 - p12) * fu + (p21 - p11) * (ONE - fu);
			acc = (acc + ONE / 2) >> FRAC_BITS;
			r.intensity = acc[INTEN_W-1:0];
			r.grad_u    = gu[GRAD_OUT_W-1:0];
			r.grad_v    = gv[GRAD_OUT_W-1:0];
			r.in_range  = 1'b1;
			return r;
		endfunction

		function void note_beat(logic k, logic [ADDR_IN_W-1:0] addr, logic [PIX_W-1:0] value,
				logic signed [COORD_W-1:0] cu, logic signed [COORD_W-1:0] cv);
			sample_res_t r;
			if (k == KIND_WRITE) begin
				if (addr < STORE_DEPTH) begin
					pix[addr]  = value;
					seen[addr] = 1'b1;
				end
				n_writes++;
			end else begin
				r = interpolate(cu, cv);
				queue_sample(r);
				n_samples++;
				if (r.in_range)
					n_inside++;
			end
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic [INTEN_W-1:0] inten, logic signed [GRAD_OUT_W-1:0] gu,
				logic signed [GRAD_OUT_W-1:0] gv, logic rng);
			sample_res_t e;
			if (pending_samples.size() == 0) begin
				report("result beat with no sample outstanding");
				return;
			end
			e = pending_samples.pop_front();
			if (inten !== e.intensity)
				report($sformatf("intensity %0d, expected %0d", inten, e.intensity));
			if (gu !== e.grad_u)
				report($sformatf("grad_u %0d, expected %0d", gu, e.grad_u));
			if (gv !== e.grad_v)
				report($sformatf("grad_v %0d, expected %0d", gv, e.grad_v));
			if (rng !== e.in_range)
				report($sformatf("in_range %0b, expected %0b", rng, e.in_range));
		endtask
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic                          kind;
	logic [ADDR_IN_W-1:0]          pixel_address;
	logic [PIX_W-1:0]              pixel_value;
	logic signed [COORD_W-1:0]     coord_u;
	logic signed [COORD_W-1:0]     coord_v;
	logic                          done;
	logic [INTEN_W-1:0]            intensity;
	logic signed [GRAD_OUT_W-1:0]  grad_u;
	logic signed [GRAD_OUT_W-1:0]  grad_v;
	logic                          in_range;
	logic                          cfg_we;
	logic [CFG_IDX_W-1:0]          cfg_addr;
	logic [CFG_DATA_W-1:0]         cfg_wdata;

	sampler_scoreboard sb = new();

	int burst_left = 0;
	int beats_sent = 0;
	int n_settings = 1;
	int idle_cycles = 0;
	int patch_col [$];
	int patch_row [$];
	int patch_w [$];
	int patch_h [$];

	bilinear_sample_with_gradient i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("timeout: no beat for %0d cycles", IDLE_LIMIT);
			$display("bilinear_sample_with_gradient test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1)
			sb.check_result(intensity, grad_u, grad_v, in_range);
	end

	function automatic int pick_frac();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return 0;
		if (r < 25)
			return ONE - 1;
		if (r < 30)
			return ONE / 2;
		return $urandom_range(0, ONE - 1);
	endfunction

	function automatic logic [PIX_W-1:0] pick_pixel();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return '0;
		if (r < 4)
			return '1;
		return PIX_W'($urandom);
	endfunction

	// true when the sample is rejected or its whole neighborhood was written
	function automatic bit reads_ok(logic signed [COORD_W-1:0] cu, logic signed [COORD_W-1:0] cv);
		int up, vp, a;
		if (cu < 0 || cv < 0)
			return 1'b1;
		up = int'(cu[COORD_W-1:FRAC_BITS]);
		vp = int'(cv[COORD_W-1:FRAC_BITS]);
		if (up > sb.col_limit() || vp > sb.row_limit())
			return 1'b1;
		a = vp * IMG_W_DEF + up;
		return sb.seen[a] && sb.seen[a + 1] && sb.seen[a + IMG_W_DEF] && sb.seen[a + IMG_W_DEF + 1];
	endfunction

	task automatic send_beat(logic k, logic [ADDR_IN_W-1:0] addr, logic [PIX_W-1:0] value,
			logic signed [COORD_W-1:0] cu, logic signed [COORD_W-1:0] cv);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
		burst_left--;
		start         <= 1'b1;
		kind          <= k;
		pixel_address <= addr;
		pixel_value   <= value;
		coord_u       <= cu;
		coord_v       <= cv;
		do @(posedge clk); while (busy);
		sb.note_beat(k, addr, value, cu, cv);
		beats_sent++;
	endtask

	task automatic write_pixel(int col, int row, logic [PIX_W-1:0] value);
		send_beat(KIND_WRITE, ADDR_IN_W'(row * IMG_W_DEF + col), value,
			COORD_W'($urandom), COORD_W'($urandom));
	endtask

	task automatic sample_raw(logic signed [COORD_W-1:0] cu, logic signed [COORD_W-1:0] cv);
		send_beat(KIND_SAMPLE, ADDR_IN_W'($urandom), PIX_W'($urandom), cu, cv);
	endtask

	task automatic sample_at(int up, int vp, int fu, int fv);
		sample_raw(COORD_W'(up * ONE + fu), COORD_W'(vp * ONE + fv));
	endtask

	task automatic sample_safe(logic signed [COORD_W-1:0] cu, logic signed [COORD_W-1:0] cv);
		// push an unsafe point below zero so it reads nothing
		if (!reads_ok(cu, cv))
			cu[COORD_W-1] = 1'b1;
		sample_raw(cu, cv);
	endtask

	task automatic sample_in_patch(int i);
		int up, vp;
		up = patch_col[i] + $urandom_range(0, patch_w[i] - 2);
		vp = patch_row[i] + $urandom_range(0, patch_h[i] - 2);
		sample_at(up, vp, pick_frac(), pick_frac());
	endtask

	// remember a filled block at the tail of the patch list
	task automatic keep_patch(int col, int row, int pw, int ph);
		patch_col.insert(patch_col.size(), col);
		patch_row.insert(patch_row.size(), row);
		patch_w.insert(patch_w.size(), pw);
		patch_h.insert(patch_h.size(), ph);
	endtask

	// fill a small block, then sample inside it
	task automatic new_patch();
		int col, row, pw, ph, c, rr;
		col = ($urandom_range(0, 4) == 0) ? sb.col_limit() : $urandom_range(0, sb.col_limit());
		row = ($urandom_range(0, 4) == 0) ? sb.row_limit() : $urandom_range(0, sb.row_limit());
		pw = $urandom_range(2, 4);
		ph = $urandom_range(2, 4);
		if (col + pw > IMG_W_DEF)
			pw = IMG_W_DEF - col;
		if (row + ph > IMG_H_DEF)
			ph = IMG_H_DEF - row;
		for (rr = 0; rr < ph; rr++)
			for (c = 0; c < pw; c++)
				write_pixel(col + c, row + rr, pick_pixel());
		keep_patch(col, row, pw, ph);
		if (patch_col.size() > 24) begin
			void'(patch_col.pop_front());
			void'(patch_row.pop_front());
			void'(patch_w.pop_front());
			void'(patch_h.pop_front());
		end
		repeat ($urandom_range(1, 6)) sample_in_patch(patch_col.size() - 1);
	endtask

	task automatic random_item();
		int pick, cl, rl;
		logic signed [COORD_W-1:0] cu, cv;
		cl = sb.col_limit();
		rl = sb.row_limit();
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			send_beat(KIND_WRITE, ADDR_IN_W'($urandom), PIX_W'($urandom),
				COORD_W'($urandom), COORD_W'($urandom));
		end else if (cl < 0 || rl < 0) begin
			sample_safe(COORD_W'($urandom), COORD_W'($urandom));
		end else if (pick < 32 || patch_col.size() == 0) begin
			new_patch();
		end else if (pick < 75) begin
			sample_in_patch($urandom_range(0, patch_col.size() - 1));
		end else if (pick < 85) begin
			// just past the column or row limit
			if ($urandom_range(0, 1))
				sample_at(cl + 1, $urandom_range(0, rl), pick_frac(), pick_frac());
			else
				sample_at($urandom_range(0, cl), rl + 1, pick_frac(), pick_frac());
		end else begin
			if ($urandom_range(0, 1)) begin
				cu = COORD_W'($urandom);
				cv = COORD_W'($urandom);
			end else begin
				cu = COORD_W'($urandom_range(0, (cl + 2) * ONE - 1));
				cv = COORD_W'($urandom_range(0, (rl + 2) * ONE - 1));
			end
			sample_safe(cu, cv);
		end
	endtask

	task automatic run_random(int n);
		int target;
		target = beats_sent + n;
		while (beats_sent < target)
			random_item();
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic set_limits(int w, int h);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= REG_WIDTH;
		cfg_wdata <= CFG_DATA_W'(w);
		@(posedge clk);
		sb.set_reg(REG_WIDTH, w);
		cfg_addr  <= REG_HEIGHT;
		cfg_wdata <= CFG_DATA_W'(h);
		@(posedge clk);
		sb.set_reg(REG_HEIGHT, h);
		cfg_we <= 1'b0;
		@(posedge clk);
		patch_col.delete();
		patch_row.delete();
		patch_w.delete();
		patch_h.delete();
		n_settings++;
	endtask

	task automatic directed_checks();
		// steepest positive gradients at the origin
		write_pixel(0, 0, 8'd0);
		write_pixel(1, 0, 8'd255);
		write_pixel(0, 1, 8'd255);
		write_pixel(1, 1, 8'd255);
		sample_at(0, 0, 0, 0);
		sample_at(0, 0, ONE / 2, ONE / 2);
		sample_at(0, 0, ONE - 1, ONE - 1);
		// last in-range anchor: full intensity, steepest negative gradients
		write_pixel(1021, 509, 8'd255);
		write_pixel(1022, 509, 8'd0);
		write_pixel(1021, 510, 8'd0);
		write_pixel(1022, 510, 8'd0);
		sample_at(1021, 509, 0, 0);
		sample_at(1021, 509, ONE - 1, ONE - 1);
		// rounding exactly on the half
		write_pixel(10, 10, 8'd0);
		write_pixel(11, 10, 8'd0);
		write_pixel(10, 11, 8'd0);
		write_pixel(11, 11, 8'd128);
		sample_at(10, 10, 1, 1);
		// one step past each limit
		sample_at(1022, 0, 0, 0);
		sample_at(0, 510, 0, 0);
		// negative floors and the coordinate extremes
		sample_raw(-19'sd1, 19'sd0);
		sample_raw(19'sd0, -19'sd256);
		sample_raw(19'sd262143, 19'sd262143);
		sample_raw(-19'sd262144, -19'sd262144);
		send_beat(KIND_WRITE, '1, 8'd255, '1, '1);
	endtask

	initial begin
		arst_n        <= 1'b0;
		start         <= 1'b0;
		kind          <= KIND_WRITE;
		pixel_address <= '0;
		pixel_value   <= '0;
		coord_u       <= '0;
		coord_v       <= '0;
		cfg_we        <= 1'b0;
		cfg_addr      <= REG_WIDTH;
		cfg_wdata     <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		directed_checks();
		run_random(100);
		wait_drained();
		run_random(100);

		set_limits(4, 4);
		run_random(120);
		set_limits(2047, 1023);
		run_random(120);
		set_limits(2, 1);
		run_random(40);
		set_limits(3, 3);
		run_random(40);
		set_limits($urandom_range(4, 1024), $urandom_range(4, 512));
		run_random(150);
		set_limits($urandom_range(4, 1024), $urandom_range(4, 512));
		run_random(150);
		set_limits(1024, 512);
		run_random(100);

		wait_drained();
		repeat (8) @(posedge clk);
		$display("covered %0d pixel writes and %0d samples (%0d inside bounds) over %0d limit settings",
			sb.n_writes, sb.n_samples, sb.n_inside, n_settings);
		$display("mismatches: %0d", sb.errors);
		if (sb.errors == 0)
			$display("bilinear_sample_with_gradient test passed");
		else
			$display("bilinear_sample_with_gradient test failed");
		$finish;
	end

endmodule
